@@ sv/dle_pkg.sv @@
// Package for the DLE packet deframer: phase and kind codes, register
// indexes and the configuration struct. No dependencies.
`default_nettype none

package dle_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ESCAPE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_ENABLE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH = 3'd4;

    localparam logic [7:0]  RST_ESCAPE     = 8'h10;
    localparam logic [7:0]  RST_START      = 8'h02;
    localparam logic [7:0]  RST_END        = 8'h03;
    localparam logic        RST_END_ENABLE = 1'b1;
    localparam logic [15:0] RST_MAX_LENGTH = 16'hffff;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_OPEN = 2'd1,
        PH_BODY = 2'd2,
        PH_ESC  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_END     = 3'd1,
        K_RESTART = 3'd2,
        K_FRAME   = 3'd3,
        K_OVER    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0]  escape_char;
        logic [7:0]  start_char;
        logic [7:0]  end_char;
        logic        end_enable;
        logic [15:0] max_length;
    } t_cfg;

endpackage

`default_nettype wire

@@ sv/dle_if.sv @@
// Valid/ready channel interfaces for the DLE packet deframer:
// raw byte input and deframed result output. No dependencies.
`default_nettype none

interface dle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [2:0]  kind;
    logic [15:0] payload_length;
    logic        last;

    modport source (output valid, output payload_byte, output kind,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input payload_byte, input kind,
                    input payload_length, input last, output ready);
endinterface

`default_nettype wire

@@ sv/dle_packet_deframer.sv @@
// Top level of the DLE packet deframer: configuration registers and core.
// Depends on dle_pkg, dle_if, dle_cfg and dle_core.
//
//   channel   dir  handshake            payload
//   i_rx      in   valid/ready          rx_byte[7:0]
//   o_res     out  valid/ready          payload_byte, kind, payload_length, last
//   i_cfg_*   in   write enable only    index[2:0], data[15:0]
//
// One byte per cycle while i_rx.ready is high; a result appears the cycle after its byte is accepted.
// The phase/count update and the result register form the only loop.
// i_rx.ready drops only while a result is held and o_res.ready is low.
// Synchronous active-low reset returns to hunting with register defaults.
`default_nettype none

module dle_packet_deframer #(
    parameter int LEN_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dle_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [dle_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    dle_in_if.sink                                   i_rx,
    dle_out_if.source                                o_res
);
    import dle_pkg::*;

    t_cfg cfg;

    dle_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dle_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_rx    (i_rx),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ sv/dle_cfg.sv @@
// Configuration register file of the DLE packet deframer.
// Depends on dle_pkg.
`default_nettype none

module dle_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dle_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [dle_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output dle_pkg::t_cfg                            o_cfg
);
    import dle_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_char <= RST_ESCAPE;
            r_cfg.start_char  <= RST_START;
            r_cfg.end_char    <= RST_END;
            r_cfg.end_enable  <= RST_END_ENABLE;
            r_cfg.max_length  <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ESCAPE:     r_cfg.escape_char <= i_cfg_data[7:0];
                CFG_START:      r_cfg.start_char  <= i_cfg_data[7:0];
                CFG_END:        r_cfg.end_char    <= i_cfg_data[7:0];
                CFG_END_ENABLE: r_cfg.end_enable  <= i_cfg_data[0];
                CFG_MAX_LENGTH: r_cfg.max_length  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/dle_core.sv @@
// Deframing state machine with byte counter and result register.
// Depends on dle_pkg and the channel interfaces in dle_if.
`default_nettype none

module dle_core #(
    parameter int LEN_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dle_pkg::t_cfg i_cfg,
    dle_in_if.sink             i_rx,
    dle_out_if.source          o_res
);
    import dle_pkg::*;

    localparam int LW = (LEN_BITS > 16) ? LEN_BITS : 16;

    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic                r_out_valid;
    logic [7:0]          r_byte, n_byte;
    t_kind               r_kind, n_kind;
    logic [15:0]         r_len, n_len;
    logic                r_last, n_last;
    logic                emit;
    logic                take;
    logic                overflow;
    logic [LW-1:0]       count_ext;
    logic [7:0]          b;

    assign b         = i_rx.rx_byte;
    assign take      = i_rx.valid && i_rx.ready;
    assign count_ext = LW'(r_count);
    assign overflow  = (count_ext >= LW'(i_cfg.max_length)) || (r_count == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        emit    = 1'b0;
        n_byte  = 8'd0;
        n_kind  = K_DATA;
        n_len   = count_ext[15:0];
        n_last  = 1'b1;
        unique case (r_phase)
            PH_HUNT: begin
                if (b == i_cfg.escape_char) n_phase = PH_OPEN;
            end
            PH_OPEN: begin
                if (b == i_cfg.start_char) begin
                    n_phase = PH_BODY;
                    n_count = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_BODY, PH_ESC: begin
                if (r_phase == PH_BODY && b == i_cfg.escape_char) begin
                    n_phase = PH_ESC;
                end else if (r_phase == PH_ESC && i_cfg.end_enable
                             && b == i_cfg.end_char) begin
                    emit    = 1'b1;
                    n_kind  = K_END;
                    n_phase = PH_HUNT;
                end else if (r_phase == PH_BODY || b == i_cfg.escape_char) begin
                    emit = 1'b1;
                    if (overflow) begin
                        n_kind  = K_OVER;
                        n_phase = PH_HUNT;
                    end else begin
                        n_byte  = b;
                        n_len   = 16'd0;
                        n_last  = 1'b0;
                        n_count = r_count + 1'b1;
                        n_phase = PH_BODY;
                    end
                end else if (b == i_cfg.start_char) begin
                    emit    = 1'b1;
                    n_kind  = i_cfg.end_enable ? K_FRAME : K_RESTART;
                    n_phase = PH_BODY;
                    n_count = '0;
                end else begin
                    emit    = 1'b1;
                    n_kind  = K_FRAME;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_byte <= n_byte;
            r_kind <= n_kind;
            r_len  <= n_len;
            r_last <= n_last;
        end
    end

    assign i_rx.ready           = !r_out_valid || o_res.ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.payload_byte   = r_byte;
    assign o_res.kind           = r_kind;
    assign o_res.payload_length = r_len;
    assign o_res.last           = r_last;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_HUNT && !r_out_valid && r_count == '0))
        else $error("reset did not clear deframer state");

    a_emit_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && emit) |-> (r_phase == PH_BODY || r_phase == PH_ESC))
        else $error("result produced outside a packet");

    a_open_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_OPEN && b == i_cfg.start_char)
        |=> (r_phase == PH_BODY && r_count == '0))
        else $error("packet open did not clear byte count");

    a_end_leaves_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && emit && n_last) |=> (r_phase == PH_HUNT || r_count == '0))
        else $error("end event left stale packet state");

endmodule

`default_nettype wire
